>>> hw/rtl/lcd_text_command_generator_assert.svh
// Assertion macros shared by the checker of the LCD text command generator.
`ifndef LCD_TEXT_COMMAND_GENERATOR_ASSERT_SVH
`define LCD_TEXT_COMMAND_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LCDTCG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcd_text_command_generator assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LCDTCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcd_text_command_generator assertion failed");

`endif

>>> hw/rtl/lcdtcg_pkg.sv
// Shared types, codes and constants of the LCD text command generator.
package lcdtcg_pkg;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_CHAR = 2'd1,
        CMD_NUM  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_FUNC_SET = 8'h38;
    localparam logic [7:0] LCD_ENTRY    = 8'h06;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
    localparam logic [7:0] LCD_LINE1    = 8'h80;
    localparam logic [7:0] LCD_LINE2    = 8'h80 + 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam int VALUE_W = 16;
    localparam int BCD_W   = 20;
    localparam int SLOT_W  = 3;

    localparam logic [1:0] LINE_ONE = 2'd1;
    localparam logic [1:0] LINE_TWO = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request
        logic conv_step; // one double-dabble step
        logic slot_inc;  // move to the next write slot
        logic out_load;  // place the current slot's write in the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t kind;
        logic conv_last;
        logic slot_present;
        logic slot_final;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/lcdtcg_ctrl.sv
// Controller state machine of the LCD text command generator.
module lcdtcg_ctrl import lcdtcg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_CONV     = 4'b0100,
        ST_EMIT     = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.kind)
                    CMD_NUM:  state_next = ST_CONV;
                    CMD_NONE: state_next = ST_IDLE;
                    default:  state_next = ST_EMIT;
                endcase
            end
            ST_CONV: begin
                ctrl.conv_step = 1'b1;
                if (status.conv_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!status.slot_present) begin
                    ctrl.slot_inc = 1'b1;
                end else if (status.out_free) begin
                    ctrl.out_load = 1'b1;
                    if (status.slot_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        ctrl.slot_inc = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/lcdtcg_datapath.sv
// Datapath: request registers, bit-serial BCD converter, write selection, output register.
module lcdtcg_datapath import lcdtcg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  ctrl_cmd_t   ctrl,
    output dp_status_t  status,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [7:0]  m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    cmd_t                cmd_reg, cmd_next;
    logic [1:0]          line_reg, line_next;
    logic [4:0]          column_reg, column_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [3:0]          bit_cnt_reg, bit_cnt_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_rs_reg, out_rs_next;
    logic                out_last_reg, out_last_next;

    logic [BCD_W-1:0]    bcd_adj;
    logic                pos_present;
    logic [7:0]          pos_byte;
    logic [3:0]          digit;
    logic                z0, z1, z2;
    logic                wr_present, wr_rs, wr_final;
    logic [7:0]          wr_byte;

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < BCD_W / 4; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    assign pos_present = (line_reg == LINE_ONE) || (line_reg == LINE_TWO);
    assign pos_byte    = ((line_reg == LINE_TWO) ? LCD_LINE2 : LCD_LINE1) + {3'b000, column_reg}
                         - 8'd1;

    assign z0 = (bcd_reg[19:16] == 4'd0);
    assign z1 = z0 && (bcd_reg[15:12] == 4'd0);
    assign z2 = z1 && (bcd_reg[11:8] == 4'd0);

    always_comb begin
        case (slot_reg)
            3'd1:    digit = bcd_reg[19:16];
            3'd2:    digit = bcd_reg[15:12];
            3'd3:    digit = bcd_reg[11:8];
            3'd4:    digit = bcd_reg[7:4];
            default: digit = bcd_reg[3:0];
        endcase
    end

    // Write for the current slot of the request.
    always_comb begin
        wr_present = 1'b1;
        wr_rs      = 1'b0;
        wr_final   = 1'b0;
        wr_byte    = pos_byte;
        case (cmd_reg)
            CMD_INIT: begin
                case (slot_reg)
                    3'd0:    wr_byte = LCD_CLEAR;
                    3'd1:    wr_byte = LCD_FUNC_SET;
                    3'd2:    wr_byte = LCD_ENTRY;
                    default: wr_byte = LCD_DISP_ON;
                endcase
                wr_final = (slot_reg == 3'd3);
            end
            CMD_CHAR: begin
                if (slot_reg == 3'd0) begin
                    wr_present = pos_present;
                end else begin
                    wr_rs    = 1'b1;
                    wr_byte  = value_reg[7:0];
                    wr_final = 1'b1;
                end
            end
            CMD_NUM: begin
                if (slot_reg == 3'd0) begin
                    wr_present = pos_present;
                end else begin
                    wr_rs    = 1'b1;
                    wr_byte  = ASCII_ZERO + {4'b0000, digit};
                    wr_final = (slot_reg == 3'd5);
                    case (slot_reg)
                        3'd1:    wr_present = !z0;
                        3'd2:    wr_present = !z1;
                        3'd3:    wr_present = !z2;
                        default: wr_present = 1'b1;
                    endcase
                end
            end
            default: wr_present = 1'b0;
        endcase
    end

    always_comb begin
        cmd_next     = cmd_reg;
        line_next    = line_reg;
        column_next  = column_reg;
        value_next   = value_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        slot_next    = slot_reg;
        if (ctrl.load) begin
            cmd_next     = cmd_t'(s_tuser);
            line_next    = s_tdata[1:0];
            column_next  = s_tdata[6:2];
            value_next   = s_tdata[22:7];
            bcd_next     = '0;
            bit_cnt_next = '0;
            slot_next    = '0;
        end else begin
            if (ctrl.conv_step) begin
                bcd_next     = {bcd_adj[BCD_W-2:0], value_reg[VALUE_W-1]};
                value_next   = {value_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 4'd1;
            end
            if (ctrl.slot_inc) begin
                slot_next = slot_reg + 3'd1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_rs_next    = out_rs_reg;
        out_last_next  = out_last_reg;
        if (ctrl.out_load) begin
            out_valid_next = 1'b1;
            out_byte_next  = wr_byte;
            out_rs_next    = wr_rs;
            out_last_next  = wr_final;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_NONE;
            bit_cnt_reg   <= '0;
            slot_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
            bit_cnt_reg   <= bit_cnt_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg     <= line_next;
        column_reg   <= column_next;
        value_reg    <= value_next;
        bcd_reg      <= bcd_next;
        out_byte_reg <= out_byte_next;
        out_rs_reg   <= out_rs_next;
        out_last_reg <= out_last_next;
    end

    assign status.kind         = cmd_reg;
    assign status.conv_last    = (bit_cnt_reg == 4'd15);
    assign status.slot_present = wr_present;
    assign status.slot_final   = wr_final;
    assign status.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hw/rtl/lcd_text_command_generator.sv
// Top level of the LCD text command generator: controller plus datapath.
// Flow: a taken request goes through the dispatch state, the bit-serial BCD conversion
// (number only, 16 BCD steps) and the emit state, which offers its writes in slot order
// and skips unneeded slots, one write slot per cycle while the output register is free.
// A new request is taken once the last write is loaded; a none request ends at dispatch.
// Reset: synchronous, active low; clears the controller state and the output valid flag.
module lcd_text_command_generator import lcdtcg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // line[1:0], column[6:2], value[22:7], zero pad[23]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // LCD bus write channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte[7:0]
    output logic        m_tuser,   // reg_select[0]
    output logic        m_tlast    // last write of the request
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // The controller takes one request at a time, walks it through the BCD
    // conversion when it shows a number, then steps through up to six write
    // slots; slots that are not needed (position for other lines, leading
    // zeros in the top three digits) are skipped.
    lcdtcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    // The datapath holds the request, the double-dabble converter and the
    // output register, which holds a finished write until the bus takes it.
    lcdtcg_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctrl     (ctrl),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hw/rtl/lcdtcg_checker.sv
// Port-level assertion checker for the LCD text command generator, with its bind.
`include "lcd_text_command_generator_assert.svh"

module lcdtcg_checker import lcdtcg_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `LCDTCG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `LCDTCG_ASSERT_NEXT(a_out_stable_data, m_tvalid && !m_tready, $stable(m_tdata))
    `LCDTCG_ASSERT_NEXT(a_out_stable_flags, m_tvalid && !m_tready, $stable(m_tlast) && $stable(m_tuser))
    `LCDTCG_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    `LCDTCG_ASSERT_NOW(a_last_cmd_is_disp_on, m_tvalid && !m_tuser && m_tlast, m_tdata == LCD_DISP_ON)

endmodule

bind lcd_text_command_generator lcdtcg_checker u_lcdtcg_checker (.*);
